FILE: design/right_triangle_solver_top_defines.svh
// ---------------------------------------------------------------------------
// Right triangle solver assertion macros
// Clocked assertion shorthands on clk_i with rst_ni as disable.
// ---------------------------------------------------------------------------
`ifndef RIGHT_TRIANGLE_SOLVER_TOP_DEFINES_SVH
`define RIGHT_TRIANGLE_SOLVER_TOP_DEFINES_SVH

// Property checked at every edge out of reset.
`define RTS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Consequence checked in the cycle after the antecedent.
`define RTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/rts_pkg.sv
// ---------------------------------------------------------------------------
// Right triangle solver package
// Shared widths, constants, arctangent table and status type.
// ---------------------------------------------------------------------------
package rts_pkg;

  localparam int HypW       = 17;
  localparam int AngleW     = 16;
  localparam int AngleShift = 5;
  localparam int AngleRound = 1 << (AngleShift - 1);
  localparam int ZQW        = AngleW + AngleShift;
  localparam int NormW      = 40;
  localparam int NormSteps  = 6;
  localparam int CordW      = 43;
  localparam int ZW         = 23;
  localparam int AtanSteps  = 24;

  localparam logic [HypW-1:0]       HypMax    = '1;
  localparam logic signed [ZW-1:0]  HalfPiQ20 = 23'sd1647099;
  localparam logic [ZQW-1:0]        HalfPiU   = 21'd1647099;

  localparam logic signed [ZW-1:0] AtanQ20 [AtanSteps] = '{
    23'sd823550, 23'sd486170, 23'sd256879, 23'sd130396,
    23'sd65451,  23'sd32757,  23'sd16383,  23'sd8192,
    23'sd4096,   23'sd2048,   23'sd1024,   23'sd512,
    23'sd256,    23'sd128,    23'sd64,     23'sd32,
    23'sd16,     23'sd8,      23'sd4,      23'sd2,
    23'sd1,      23'sd0,      23'sd0,      23'sd0
  };

  typedef struct packed {
    logic valid;
    logic degenerate;
  } out_stat_t;

endpackage

FILE: design/rts_in_if.sv
// ---------------------------------------------------------------------------
// Right triangle solver input channel
// Valid/ready channel carrying the two legs of one item.
// ---------------------------------------------------------------------------
interface rts_in_if #(
  parameter int SIDE_WIDTH = 16
) ();

  logic                  valid;
  logic                  ready;
  logic [SIDE_WIDTH-1:0] side_a;
  logic [SIDE_WIDTH-1:0] side_b;

  modport source (output valid, output side_a, output side_b, input ready);
  modport sink   (input valid, input side_a, input side_b, output ready);

endinterface

FILE: design/rts_out_if.sv
// ---------------------------------------------------------------------------
// Right triangle solver output channel
// Valid/ready channel carrying hypotenuse, both angles and the zero flag.
// ---------------------------------------------------------------------------
interface rts_out_if ();

  logic                       valid;
  logic                       ready;
  logic [rts_pkg::HypW-1:0]   hypotenuse;
  logic [rts_pkg::AngleW-1:0] angle_a;
  logic [rts_pkg::AngleW-1:0] angle_b;
  logic                       degenerate;

  modport source (output valid, output hypotenuse, output angle_a, output angle_b,
                  output degenerate, input ready);
  modport sink   (input valid, input hypotenuse, input angle_a, input angle_b,
                  input degenerate, output ready);

endinterface

FILE: design/rts_pipe_ctrl.sv
// ---------------------------------------------------------------------------
// Right triangle solver pipeline control
// Per-stage valid bits, stage enables with bubble collapse, zero-leg flag.
// ---------------------------------------------------------------------------
`include "right_triangle_solver_top_defines.svh"

module rts_pipe_ctrl #(
  parameter int DEPTH = 23
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               zero_i,
  input  logic               out_ready_i,
  output logic               in_ready_o,
  output logic [DEPTH:0]     en_o,
  output rts_pkg::out_stat_t stat_o
);

  logic [DEPTH:0] v_q;
  logic [DEPTH:0] deg_q;
  logic           in_acc;
  logic           out_acc;

  always_comb begin
    logic [DEPTH:0] low;
    for (int k = 0; k <= DEPTH; k++) begin
      low     = ((DEPTH+1)'(1) << k) - (DEPTH+1)'(1);
      en_o[k] = out_ready_i || ((v_q | low) != '1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en_o[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k <= DEPTH; k++) begin
        if (en_o[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_o[0]) begin
      deg_q[0] <= zero_i;
    end
    for (int k = 1; k <= DEPTH; k++) begin
      if (en_o[k]) begin
        deg_q[k] <= deg_q[k-1];
      end
    end
  end

  assign in_ready_o        = en_o[0];
  assign stat_o.valid      = v_q[DEPTH];
  assign stat_o.degenerate = deg_q[DEPTH];
  assign in_acc            = in_valid_i && in_ready_o;
  assign out_acc           = v_q[DEPTH] && out_ready_i;

  `RTS_ASSERT(a_ready_with_room, !v_q[DEPTH] |-> in_ready_o, "input stalled with empty output stage")
  `RTS_ASSERT_NEXT(a_count_hold, !in_acc && !out_acc, $countones(v_q) == $past($countones(v_q)), "item count changed while idle")
  `RTS_ASSERT_NEXT(a_count_gain, in_acc && !out_acc, $countones(v_q) == $past($countones(v_q)) + 1, "accepted item lost")
  `RTS_ASSERT_NEXT(a_count_drop, !in_acc && out_acc, $countones(v_q) + 1 == $past($countones(v_q)), "delivered item repeated")

endmodule

FILE: design/rts_hyp_pipe.sv
// ---------------------------------------------------------------------------
// Right triangle solver hypotenuse path
// Squares, sum, one square-root digit per stage, rounding and saturation.
// ---------------------------------------------------------------------------
module rts_hyp_pipe #(
  parameter int SIDE_WIDTH = 16,
  parameter int DEPTH      = 23
) (
  input  logic                     clk_i,
  input  logic [DEPTH:0]           en_i,
  input  logic [SIDE_WIDTH-1:0]    side_a_i,
  input  logic [SIDE_WIDTH-1:0]    side_b_i,
  output logic [rts_pkg::HypW-1:0] hyp_o
);

  localparam int PW     = 2 * SIDE_WIDTH;
  localparam int RB     = SIDE_WIDTH + 1;
  localparam int SqW    = 2 * RB;
  localparam int RemW   = RB + 2;
  localparam int CmpW   = (RB + 1 > rts_pkg::HypW) ? RB + 1 : rts_pkg::HypW;
  localparam int HypLen = RB + 3;
  localparam int DlyN   = DEPTH - HypLen;

  logic [SIDE_WIDTH-1:0]    ra_q;
  logic [SIDE_WIDTH-1:0]    rb_q;
  logic [PW-1:0]            sa_q;
  logic [PW-1:0]            sb_q;
  logic [SqW-1:0]           s_q    [RB+1];
  logic [RemW-1:0]          rem_q  [RB+1];
  logic [RB-1:0]            root_q [RB+1];
  logic [rts_pkg::HypW-1:0] hy_q   [DlyN+1];

  function automatic logic [RemW+RB-1:0] sqrt_digit(input logic [RemW-1:0] rem,
                                                    input logic [RB-1:0]   root,
                                                    input logic [1:0]      pair);
    logic [RemW-1:0] sh;
    logic [RemW-1:0] trial;
    sh    = {rem[RemW-3:0], pair};
    trial = {root, 2'b01};
    if (sh >= trial) begin
      return {sh - trial, root[RB-2:0], 1'b1};
    end
    return {sh, root[RB-2:0], 1'b0};
  endfunction

  function automatic logic [rts_pkg::HypW-1:0] round_sat(input logic [RemW-1:0] rem,
                                                         input logic [RB-1:0]   root);
    logic [CmpW-1:0] r;
    r = CmpW'(root) + CmpW'(rem > RemW'(root));
    if (r > CmpW'(rts_pkg::HypMax)) begin
      return rts_pkg::HypMax;
    end
    return r[rts_pkg::HypW-1:0];
  endfunction

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      ra_q <= side_a_i;
      rb_q <= side_b_i;
    end
    if (en_i[1]) begin
      sa_q <= PW'(ra_q) * PW'(ra_q);
      sb_q <= PW'(rb_q) * PW'(rb_q);
    end
    if (en_i[2]) begin
      s_q[0]    <= SqW'(sa_q) + SqW'(sb_q);
      rem_q[0]  <= '0;
      root_q[0] <= '0;
    end
    for (int j = 0; j < RB; j++) begin
      if (en_i[3+j]) begin
        s_q[j+1]                  <= s_q[j];
        {rem_q[j+1], root_q[j+1]} <= sqrt_digit(rem_q[j], root_q[j],
                                                s_q[j][2*(RB-1-j) +: 2]);
      end
    end
    if (en_i[HypLen]) begin
      hy_q[0] <= round_sat(rem_q[RB], root_q[RB]);
    end
    for (int d = 1; d <= DlyN; d++) begin
      if (en_i[HypLen+d]) begin
        hy_q[d] <= hy_q[d-1];
      end
    end
  end

  assign hyp_o = hy_q[DlyN];

endmodule

FILE: design/rts_atan_pipe.sv
// ---------------------------------------------------------------------------
// Right triangle solver angle path
// Leading-zero normalization, CORDIC vectoring stages, clamp and rounding.
// ---------------------------------------------------------------------------
module rts_atan_pipe #(
  parameter int SIDE_WIDTH = 16,
  parameter int ITERATIONS = 16,
  parameter int DEPTH      = 23
) (
  input  logic                       clk_i,
  input  logic [DEPTH:0]             en_i,
  input  logic [SIDE_WIDTH-1:0]      side_a_i,
  input  logic [SIDE_WIDTH-1:0]      side_b_i,
  output logic [rts_pkg::AngleW-1:0] angle_a_o,
  output logic [rts_pkg::AngleW-1:0] angle_b_o
);

  localparam int NW     = rts_pkg::NormW;
  localparam int NS     = rts_pkg::NormSteps;
  localparam int CW     = rts_pkg::CordW;
  localparam int ZW     = rts_pkg::ZW;
  localparam int ZQW    = rts_pkg::ZQW;
  localparam int AW     = rts_pkg::AngleW;
  localparam int AngLen = NS + ITERATIONS + 1;
  localparam int DlyN   = DEPTH - AngLen;

  logic [NW-1:0]        nm_q [NS];
  logic [NW-1:0]        nx_q [NS];
  logic [NW-1:0]        ny_q [NS];
  logic signed [CW-1:0] cx_q [ITERATIONS+1];
  logic signed [CW-1:0] cy_q [ITERATIONS+1];
  logic signed [ZW-1:0] cz_q [ITERATIONS+1];
  logic [ZQW-1:0]       zc;
  logic [AW-1:0]        aa_q [DlyN+1];
  logic [AW-1:0]        ab_q [DlyN+1];

  function automatic logic [NW-1:0] norm_apply(input logic [NW-1:0] v,
                                               input logic [NW-1:0] m,
                                               input int            s);
    if ((m >> (NW - s)) == '0) begin
      return v << s;
    end
    return v;
  endfunction

  function automatic logic [AW-1:0] round_angle(input logic [ZQW-1:0] v);
    logic [ZQW-1:0] t;
    t = v + ZQW'(rts_pkg::AngleRound);
    return t[ZQW-1 -: AW];
  endfunction

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      nm_q[0] <= NW'((side_a_i > side_b_i) ? side_a_i : side_b_i);
      nx_q[0] <= NW'(side_b_i);
      ny_q[0] <= NW'(side_a_i);
    end
    for (int k = 1; k < NS; k++) begin
      if (en_i[k]) begin
        nm_q[k] <= norm_apply(nm_q[k-1], nm_q[k-1], 1 << (NS - k));
        nx_q[k] <= norm_apply(nx_q[k-1], nm_q[k-1], 1 << (NS - k));
        ny_q[k] <= norm_apply(ny_q[k-1], nm_q[k-1], 1 << (NS - k));
      end
    end
    if (en_i[NS]) begin
      cx_q[0] <= $signed({{(CW-NW){1'b0}}, norm_apply(nx_q[NS-1], nm_q[NS-1], 1)});
      cy_q[0] <= $signed({{(CW-NW){1'b0}}, norm_apply(ny_q[NS-1], nm_q[NS-1], 1)});
      cz_q[0] <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < ITERATIONS; i++) begin
      if (en_i[NS+1+i]) begin
        if (cy_q[i][CW-1]) begin
          cx_q[i+1] <= cx_q[i] - (cy_q[i] >>> i);
          cy_q[i+1] <= cy_q[i] + (cx_q[i] >>> i);
          cz_q[i+1] <= cz_q[i] - rts_pkg::AtanQ20[i];
        end else begin
          cx_q[i+1] <= cx_q[i] + (cy_q[i] >>> i);
          cy_q[i+1] <= cy_q[i] - (cx_q[i] >>> i);
          cz_q[i+1] <= cz_q[i] + rts_pkg::AtanQ20[i];
        end
      end
    end
  end

  always_comb begin
    if (cz_q[ITERATIONS] < 0) begin
      zc = '0;
    end else if (cz_q[ITERATIONS] > rts_pkg::HalfPiQ20) begin
      zc = rts_pkg::HalfPiU;
    end else begin
      zc = cz_q[ITERATIONS][ZQW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[AngLen]) begin
      aa_q[0] <= round_angle(zc);
      ab_q[0] <= round_angle(rts_pkg::HalfPiU - zc);
    end
    for (int d = 1; d <= DlyN; d++) begin
      if (en_i[AngLen+d]) begin
        aa_q[d] <= aa_q[d-1];
        ab_q[d] <= ab_q[d-1];
      end
    end
  end

  assign angle_a_o = aa_q[DlyN];
  assign angle_b_o = ab_q[DlyN];

endmodule

FILE: design/right_triangle_solver_top.sv
// ---------------------------------------------------------------------------
// Right triangle solver top level
// Legs in, hypotenuse and both acute angles out, one item per cycle while the output accepts.
// ---------------------------------------------------------------------------
//  channel | dir | fields                                        | handshake
//  in_i    | in  | side_a, side_b                                | valid/ready
//  out_o   | out | hypotenuse, angle_a, angle_b, degenerate      | valid/ready
//
//  Throughput one item per cycle while the output is not stalled.
//  Depth is set by the square-root digit stages and the CORDIC micro-rotation
//  stages running side by side; the shorter path is delayed to match.
//  Reset clears only the stage valid bits.
//  A stalled output holds; upstream stages keep filling bubbles, so input
//  is accepted until every stage holds an item.
// ---------------------------------------------------------------------------
module right_triangle_solver_top #(
  parameter int SIDE_WIDTH = 16,
  parameter int ITERATIONS = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  rts_in_if.sink   in_i,
  rts_out_if.source out_o
);

  localparam int HypLen = SIDE_WIDTH + 4;
  localparam int AngLen = rts_pkg::NormSteps + ITERATIONS + 1;
  localparam int Depth  = (HypLen > AngLen) ? HypLen : AngLen;

  logic [Depth:0]             en;
  logic                       in_ready;
  logic                       zero_in;
  rts_pkg::out_stat_t         stat;
  logic [rts_pkg::HypW-1:0]   hyp;
  logic [rts_pkg::AngleW-1:0] ang_a;
  logic [rts_pkg::AngleW-1:0] ang_b;

  assign zero_in = (in_i.side_a == '0) && (in_i.side_b == '0);

  rts_pipe_ctrl #(
    .DEPTH (Depth)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .zero_i      (zero_in),
    .out_ready_i (out_o.ready),
    .in_ready_o  (in_ready),
    .en_o        (en),
    .stat_o      (stat)
  );

  rts_hyp_pipe #(
    .SIDE_WIDTH (SIDE_WIDTH),
    .DEPTH      (Depth)
  ) u_hyp (
    .clk_i    (clk_i),
    .en_i     (en),
    .side_a_i (in_i.side_a),
    .side_b_i (in_i.side_b),
    .hyp_o    (hyp)
  );

  rts_atan_pipe #(
    .SIDE_WIDTH (SIDE_WIDTH),
    .ITERATIONS (ITERATIONS),
    .DEPTH      (Depth)
  ) u_atan (
    .clk_i     (clk_i),
    .en_i      (en),
    .side_a_i  (in_i.side_a),
    .side_b_i  (in_i.side_b),
    .angle_a_o (ang_a),
    .angle_b_o (ang_b)
  );

  assign in_i.ready       = in_ready;
  assign out_o.valid      = stat.valid;
  assign out_o.degenerate = stat.degenerate;
  assign out_o.hypotenuse = stat.degenerate ? '0 : hyp;
  assign out_o.angle_a    = stat.degenerate ? '0 : ang_a;
  assign out_o.angle_b    = stat.degenerate ? '0 : ang_b;

endmodule
